/* rtl/dsrs_pkg.sv */
// Shared types for the dynamic sequence range sum block.
// Operation and status codes, the controller state type and the cell command.
// No dependencies.
package dsrs_pkg;

  localparam int SUM_BITS   = 40;
  localparam int OP_BITS    = 2;
  localparam int POS_BITS   = 9;
  localparam int REND_BITS  = 8;
  localparam int IN_BITS    = 32;
  localparam int COUNT_BITS = 9;
  localparam int STAT_BITS  = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_ADD    = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [STAT_BITS-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic ins;
    logic del;
    logic add;
    logic rot;
  } cell_cmd_t;

endpackage

/* rtl/dsrs_cell.sv */
// One storage cell of the sequence chain: holds one element.
// Shifts from its neighbors on insert, erase and scan rotation; adds in place.
// Depends on dsrs_pkg.
module dsrs_cell
  import dsrs_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int PW         = 9,
  parameter int IDX        = 0
) (
  input  logic                  clk_i,
  input  cell_cmd_t             cmd_i,
  input  logic [PW-1:0]         pos_i,
  input  logic [VALUE_BITS-1:0] val_i,
  input  logic [VALUE_BITS-1:0] left_i,
  input  logic [VALUE_BITS-1:0] right_i,
  output logic [VALUE_BITS-1:0] elem_o
);

  localparam logic [PW-1:0] MyIdx = PW'(IDX);

  logic [VALUE_BITS-1:0] elem_q, elem_d;

  always_comb begin
    elem_d = elem_q;
    priority if (cmd_i.rot) begin
      elem_d = right_i;
    end else if (cmd_i.ins) begin
      if (MyIdx > pos_i) begin
        elem_d = left_i;
      end else if (MyIdx == pos_i) begin
        elem_d = val_i;
      end
    end else if (cmd_i.del) begin
      if (MyIdx >= pos_i) begin
        elem_d = right_i;
      end
    end else if (cmd_i.add) begin
      if (MyIdx == pos_i) begin
        elem_d = elem_q + val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  assign elem_o = elem_q;

endmodule

/* rtl/dynamic_sequence_range_sum.sv */
// Insert, erase and add finish in the execute state; a valid range query then moves to
// the scan state, where the chain rotates once past the accumulator. Failed operations
// finish in the execute state without a scan.
// A new item is accepted only in the idle state, after the previous one has finished.
// Reset clears the element count and the controller; cell contents stay undefined.
// Results are shown for one cycle on done_o; the receiver cannot stall.
module dynamic_sequence_range_sum
  import dsrs_pkg::*;
#(
  parameter int DEPTH      = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [OP_BITS-1:0]     op_i,
  input  logic [POS_BITS-1:0]    pos_i,
  input  logic [REND_BITS-1:0]   right_end_i,
  input  logic signed [IN_BITS-1:0] value_i,
  output logic                   done_o,
  output logic signed [SUM_BITS-1:0] sum_o,
  output logic [COUNT_BITS-1:0]  count_o,
  output logic [STAT_BITS-1:0]   status_o
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int PW   = (CW > POS_BITS) ? CW : POS_BITS;
  localparam int FW   = (VALUE_BITS > IN_BITS) ? VALUE_BITS : IN_BITS;
  localparam int XW   = (VALUE_BITS > SUM_BITS) ? VALUE_BITS : SUM_BITS;
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);
  localparam logic [IW-1:0] LastIdx   = IW'(DEPTH - 1);

  state_e state_q, state_d;
  op_e    op_q;
  logic [PW-1:0]         pos_q, rend_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CW-1:0]         count_q;
  logic [IW-1:0]         k_q;
  logic [SUM_BITS-1:0]   acc_q, acc_d, sum_q;
  status_e               status_q, status_d;
  logic                  done_q;

  logic [PW-1:0] cnt_ext, rend_clamp, ins_pos, cell_pos, k_ext;
  logic          in_range, hit;
  logic [XW-1:0] head_ext;
  cell_cmd_t     cmd;
  logic [VALUE_BITS-1:0] elem [DEPTH];

  // ---- command evaluation ----
  assign cnt_ext    = PW'(count_q);
  assign in_range   = pos_q < cnt_ext;
  assign rend_clamp = (rend_q >= cnt_ext) ? cnt_ext - PW'(1) : rend_q;
  assign ins_pos    = (pos_q > cnt_ext) ? cnt_ext : pos_q;
  assign cell_pos   = (op_q == OP_INSERT) ? ins_pos : pos_q;

  always_comb begin
    status_d = ST_OK;
    unique case (op_q)
      OP_INSERT: status_d = (count_q == FullCount) ? ST_FULL : ST_OK;
      OP_ERASE,
      OP_ADD:    status_d = in_range ? ST_OK : ST_BAD;
      OP_QUERY:  status_d = (in_range && (pos_q <= rend_clamp)) ? ST_OK : ST_BAD;
      default:   status_d = ST_BAD;
    endcase
  end

  // ---- scan accumulator ----
  assign k_ext    = PW'(k_q);
  assign hit      = (k_ext >= pos_q) && (k_ext <= rend_q);
  assign head_ext = XW'($signed(elem[0]));
  assign acc_d    = acc_q + (hit ? head_ext[SUM_BITS-1:0] : '0);

  // ---- controller ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start) begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = (op_q == OP_QUERY && status_d == ST_OK) ? S_SCAN : S_IDLE;
      end
      S_SCAN: if (k_q == LastIdx) begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_q)
      S_IDLE: busy = 1'b0;
      S_EXEC: if (status_d == ST_OK) begin
        cmd.ins = (op_q == OP_INSERT);
        cmd.del = (op_q == OP_ERASE);
        cmd.add = (op_q == OP_ADD);
      end
      S_SCAN: cmd.rot = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == S_EXEC) && (op_q != OP_QUERY || status_d != ST_OK)) ||
                 ((state_q == S_SCAN) && (k_q == LastIdx));
      if (state_q == S_EXEC) begin
        k_q <= '0;
        if (status_d == ST_OK && op_q == OP_INSERT) begin
          count_q <= count_q + CW'(1);
        end
        if (status_d == ST_OK && op_q == OP_ERASE) begin
          count_q <= count_q - CW'(1);
        end
      end
      if (state_q == S_SCAN) begin
        k_q <= k_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      op_q   <= op_e'(op_i);
      pos_q  <= PW'(pos_i);
      rend_q <= PW'(right_end_i);
      val_q  <= VALUE_BITS'(FW'(value_i));
    end
    if (state_q == S_EXEC) begin
      status_q <= status_d;
      sum_q    <= '0;
      acc_q    <= '0;
      rend_q   <= rend_clamp;
    end
    if (state_q == S_SCAN) begin
      acc_q <= acc_d;
      if (k_q == LastIdx) begin
        sum_q    <= acc_d;
        status_q <= ST_OK;
      end
    end
  end

  // ---- cell chain ----
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = elem[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = elem[0];
    end else begin : g_inner
      assign right = elem[i+1];
    end
    dsrs_cell #(
      .VALUE_BITS(VALUE_BITS),
      .PW        (PW),
      .IDX       (i)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .pos_i  (cell_pos),
      .val_i  (val_q),
      .left_i (left),
      .right_i(right),
      .elem_o (elem[i])
    );
  end

  assign done_o   = done_q;
  assign sum_o    = sum_q;
  assign count_o  = COUNT_BITS'(count_q);
  assign status_o = status_q;

endmodule

/* rtl/dsrs_checker.sv */
// Port-level checks for dynamic_sequence_range_sum, bound to the top level.
// Depends on dsrs_pkg.
module dsrs_checker
  import dsrs_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic                  done_o,
  input logic [SUM_BITS-1:0]   sum_o,
  input logic [STAT_BITS-1:0]  status_o
);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result beat while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o)) else $error("accepted beat did not go busy");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("back-to-back result beats");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (sum_o == '0)) else $error("nonzero sum on failure");

endmodule

bind dynamic_sequence_range_sum dsrs_checker u_dsrs_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .done_o  (done_o),
  .sum_o   (sum_o),
  .status_o(status_o)
);

/* tb/tb_top.sv */
// Self-checking testbench for dynamic_sequence_range_sum: a shadow sequence predicts
// each beat's sum, count and status; results are checked in order against it.
// Depends on dsrs_pkg and the dynamic_sequence_range_sum RTL.
`timescale 1ns / 100ps

module tb_top
  import dsrs_pkg::*;
();

  localparam int DEPTH       = 256;
  localparam int VALUE_BITS  = 32;
  localparam int TOTAL_ITEMS = 1950;
  localparam int CALM_ITEMS  = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  typedef enum int {
    PH_FILL,
    PH_MIX,
    PH_DRAIN
  } phase_e;

  typedef struct {
    op_e                          op;
    logic signed [SUM_BITS-1:0]   sum;
    logic [COUNT_BITS-1:0]        count;
    status_e                      status;
  } seq_result_t;

  class seq_scoreboard;
    logic signed [IN_BITS-1:0] shadow_seq[$];
    seq_result_t               pending_results[$];
    int                        n_mismatch;
    int                        n_checked;
    int                        hits[4][3];
    int                        peak_count;

    function new();
      n_mismatch = 0;
      n_checked  = 0;
      peak_count = 0;
      foreach (hits[i, j]) hits[i][j] = 0;
    endfunction

    function void note_command(op_e op, logic [POS_BITS-1:0] pos,
                               logic [REND_BITS-1:0] rend,
                               logic signed [IN_BITS-1:0] val);
      seq_result_t r;
      int unsigned n;
      int unsigned hi;
      n        = shadow_seq.size();
      r.op     = op;
      r.sum    = '0;
      r.status = ST_OK;
      case (op)
        OP_INSERT: begin
          if (n >= DEPTH) r.status = ST_FULL;
          else if (pos >= n) shadow_seq.push_back(val);
          else shadow_seq.insert(pos, val);
        end
        OP_ERASE: begin
          if (pos >= n) r.status = ST_BAD;
          else shadow_seq.delete(pos);
        end
        OP_ADD: begin
          if (pos >= n) r.status = ST_BAD;
          else shadow_seq[pos] = shadow_seq[pos] + val;
        end
        default: begin
          if (n == 0 || pos >= n) begin
            r.status = ST_BAD;
          end else begin
            hi = (rend >= n) ? n - 1 : rend;
            if (pos > hi) begin
              r.status = ST_BAD;
            end else begin
              for (int unsigned i = pos; i <= hi; i++)
                r.sum = r.sum + {{(SUM_BITS-IN_BITS){shadow_seq[i][IN_BITS-1]}},
                                 shadow_seq[i]};
            end
          end
        end
      endcase
      r.count = COUNT_BITS'(shadow_seq.size());
      if (shadow_seq.size() > peak_count) peak_count = shadow_seq.size();
      hits[op][r.status]++;
      pending_results.push_back(r);
    endfunction

    function void check_result(logic signed [SUM_BITS-1:0] sum,
                               logic [COUNT_BITS-1:0] count,
                               logic [STAT_BITS-1:0] status);
      seq_result_t r;
      n_checked++;
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("[%0t] unexpected result beat: sum=%0d count=%0d status=%0d",
                   $realtime, sum, count, status);
        return;
      end
      r = pending_results.pop_front();
      if (sum !== r.sum || count !== r.count || status !== r.status) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("[%0t] %s mismatch: sum exp %0d got %0d, count exp %0d got %0d, status exp %0d got %0d",
                   $realtime, r.op.name(), r.sum, sum, r.count, count, r.status, status);
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  op_e                           op_q;
  logic [POS_BITS-1:0]           pos_q;
  logic [REND_BITS-1:0]          rend_q;
  logic signed [IN_BITS-1:0]     value_q;
  logic                          done_o;
  logic signed [SUM_BITS-1:0]    sum_o;
  logic [COUNT_BITS-1:0]         count_o;
  logic [STAT_BITS-1:0]          status_o;

  seq_scoreboard sb;
  int            n_sent;

  dynamic_sequence_range_sum #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (op_q),
    .pos_i       (pos_q),
    .right_end_i (rend_q),
    .value_i     (value_q),
    .done_o      (done_o),
    .sum_o       (sum_o),
    .count_o     (count_o),
    .status_o    (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // result beats
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(sum_o, count_o, status_o);
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) stall = 0;
      else stall++;
      if (stall >= STALL_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_cmd(input op_e o, input logic [POS_BITS-1:0] p,
                          input logic [REND_BITS-1:0] r,
                          input logic signed [IN_BITS-1:0] v);
    start   <= 1'b1;
    op_q    <= o;
    pos_q   <= p;
    rend_q  <= r;
    value_q <= v;
    do @(posedge clk_i); while (busy);
    sb.note_command(o, p, r, v);
    n_sent++;
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(13, 1)) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic void pick_command(input phase_e ph, input int unsigned n,
                                       output op_e o, output logic [POS_BITS-1:0] p,
                                       output logic [REND_BITS-1:0] r,
                                       output logic signed [IN_BITS-1:0] v);
    int unsigned roll;
    int unsigned w_ins;
    int unsigned w_era;
    int unsigned w_add;
    case (ph)
      PH_FILL:  begin w_ins = 80; w_era = 5;  w_add = 7;  end
      PH_DRAIN: begin w_ins = 10; w_era = 70; w_add = 10; end
      default:  begin w_ins = 35; w_era = 30; w_add = 15; end
    endcase
    roll = $urandom_range(99);
    if (roll < w_ins) o = OP_INSERT;
    else if (roll < w_ins + w_era) o = OP_ERASE;
    else if (roll < w_ins + w_era + w_add) o = OP_ADD;
    else o = OP_QUERY;

    roll = $urandom_range(99);
    if (roll < 10) begin
      p = POS_BITS'($urandom());
    end else if (roll < 20) begin
      case ($urandom_range(3))
        0: p = POS_BITS'(n);
        1: p = POS_BITS'(n + 1);
        2: p = POS_BITS'(DEPTH);
        default: p = '0;
      endcase
    end else if (o == OP_INSERT) begin
      p = POS_BITS'($urandom_range(n));
    end else begin
      p = (n == 0) ? '0 : POS_BITS'($urandom_range(n - 1));
    end

    roll = $urandom_range(99);
    if (roll < 40) r = REND_BITS'(p) + REND_BITS'($urandom_range(7));
    else if (roll < 70) r = REND_BITS'($urandom_range(255));
    else if (roll < 85) r = '1;
    else r = (n == 0) ? '0 : REND_BITS'(n - 1);

    roll = $urandom_range(99);
    if (roll < 20) begin
      case ($urandom_range(3))
        0: v = 32'sh7fff_ffff;
        1: v = 32'sh8000_0000;
        2: v = -32'sd1;
        default: v = '0;
      endcase
    end else if (roll < 60) begin
      v = $urandom();
    end else begin
      v = $signed($urandom_range(200)) - 100;
    end
  endfunction

  initial begin
    phase_e                     ph;
    int                         seg_len;
    bit                         idle_on;
    bit                         paused_once;
    op_e                        o;
    logic [POS_BITS-1:0]        p;
    logic [REND_BITS-1:0]       r;
    logic signed [IN_BITS-1:0]  v;

    sb          = new();
    n_sent      = 0;
    paused_once = 1'b0;
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    op_q    <= OP_INSERT;
    pos_q   <= '0;
    rend_q  <= '0;
    value_q <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty store, appends, wrap on add, clamped and inverted ranges
    send_cmd(OP_QUERY,  9'd0,   8'd0,   32'sd5);
    send_cmd(OP_ERASE,  9'd0,   8'd0,   32'sd0);
    send_cmd(OP_ADD,    9'd0,   8'd0,   32'sd1);
    send_cmd(OP_INSERT, 9'd0,   8'd0,   32'sh7fff_ffff);
    send_cmd(OP_INSERT, 9'd511, 8'd255, 32'sh8000_0000);
    send_cmd(OP_INSERT, 9'd1,   8'd0,   -32'sd1);
    send_cmd(OP_INSERT, 9'd0,   8'd0,   32'sd0);
    send_cmd(OP_ADD,    9'd1,   8'd0,   32'sh7fff_ffff);
    send_cmd(OP_ADD,    9'd1,   8'd0,   32'sd1);
    send_cmd(OP_ADD,    9'd4,   8'd0,   32'sd1);
    send_cmd(OP_ADD,    9'd256, 8'd0,   32'sd1);
    send_cmd(OP_QUERY,  9'd0,   8'd255, 32'sd0);
    send_cmd(OP_QUERY,  9'd2,   8'd1,   32'sd0);
    send_cmd(OP_QUERY,  9'd4,   8'd4,   32'sd0);
    send_cmd(OP_QUERY,  9'd300, 8'd255, 32'sd0);
    send_cmd(OP_QUERY,  9'd1,   8'd1,   32'sd0);
    send_cmd(OP_ERASE,  9'd4,   8'd0,   32'sd0);
    send_cmd(OP_ERASE,  9'd3,   8'd0,   32'sd0);
    send_cmd(OP_ERASE,  9'd0,   8'd0,   32'sd0);
    send_cmd(OP_QUERY,  9'd0,   8'd0,   32'sd0);
    send_cmd(OP_QUERY,  9'd0,   8'd255, 32'sd0);

    ph = PH_FILL;
    while (n_sent < TOTAL_ITEMS) begin
      seg_len = (ph == PH_FILL) ? $urandom_range(500, 400) : $urandom_range(400, 150);
      idle_on = $urandom_range(1);
      for (int k = 0; k < seg_len && n_sent < TOTAL_ITEMS; k++) begin
        pick_command(ph, sb.shadow_seq.size(), o, p, r, v);
        send_cmd(o, p, r, v);
        if (idle_on && n_sent < TOTAL_ITEMS - CALM_ITEMS && $urandom_range(99) < 30)
          idle_burst();
      end
      if (!paused_once || $urandom_range(1)) begin
        wait_drained();
        paused_once = 1'b1;
      end
      case (ph)
        PH_FILL:  ph = PH_MIX;
        PH_MIX:   ph = ($urandom_range(1)) ? PH_DRAIN : PH_FILL;
        default:  ph = PH_MIX;
      endcase
    end

    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d beats, %0d results; peak depth %0d, full-store inserts %0d,",
             n_sent, sb.n_checked, sb.peak_count, sb.hits[OP_INSERT][ST_FULL]);
    $display("good queries %0d, bad index/range %0d, mismatches %0d",
             sb.hits[OP_QUERY][ST_OK],
             sb.hits[OP_ERASE][ST_BAD] + sb.hits[OP_ADD][ST_BAD] + sb.hits[OP_QUERY][ST_BAD],
             sb.n_mismatch);
    if (sb.n_mismatch == 0 && sb.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
